// ===== src/torque_window_peak_to_drive_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the torque window peak to drive block
// Property wrappers on clk_i with rst_ni as the disable condition.
// ----------------------------------------------------------------------------
`ifndef TORQUE_WINDOW_PEAK_TO_DRIVE_ASSERT_SVH
`define TORQUE_WINDOW_PEAK_TO_DRIVE_ASSERT_SVH

// consequent checked on the same edge
`define TWPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked on the next edge
`define TWPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/twpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive package
// Shared constants, widths and types for the front, queue and back parts.
// ----------------------------------------------------------------------------
package twpd_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int OUT_MIN      = 0;

  localparam int ADC_SPAN = 4096;
  localparam int MV_SPAN  = 3301;
  localparam int MV_CLAMP = 1500;
  localparam int MAP_SPAN = 1501;

  localparam int GEAR_COUNT = 5;
  localparam int FIFO_DEPTH = 2;

  localparam int SAMPLE_W = 12;
  localparam int GEAR_W   = 3;
  localparam int DRIVE_W  = 8;
  localparam int LEN_W    = 5;
  localparam int OFFS_W   = 12;
  localparam int TOP_W    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam int ADC_SHIFT = $clog2(ADC_SPAN);
  localparam int MVP_W     = SAMPLE_W + $clog2(MV_SPAN + 1);
  localparam int MVC_W     = $clog2(MV_CLAMP + 1);
  localparam int MAG_W     = MVC_W + TOP_W;
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / MAP_SPAN;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam int QUOT_W    = TOP_W + 1;
  localparam int REM_W     = MAG_W + 1;
  localparam int SLOPE_W   = TOP_W + 2;
  localparam int RES_W     = TOP_W + 3;
  localparam int DRIVE_MAX = 255;

  localparam logic [LEN_W-1:0] WIN_LEN_RESET = LEN_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MV  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR1_MAX  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR2_MAX  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR3_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR4_MAX  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR5_MAX  = 4'd7;

  typedef struct packed {
    logic                store;
    logic [GEAR_W-1:0]   gear;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                             enable;
    logic [LEN_W-1:0]                 window_len;
    logic [OFFS_W-1:0]                offset_mv;
    logic [GEAR_COUNT-1:0][TOP_W-1:0] gear_max;
  } cfg_t;

endpackage

// ===== src/torque_window_peak_to_drive.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive
// Each beat brings a torque sample and a gear and returns one drive value:
// the peak of the newest window_len stored samples, converted to millivolts,
// offset, clamped and scaled by the gear's full-torque value. The back
// sequencer scans min(window_len, WINDOW_DEPTH) entries, and the window scan
// reads one entry per cycle; then the arithmetic runs through MUL, SUB, SLOPE,
// RECIP, QUOT and FIX, one step per cycle, but FIX waits while the output
// register holds a result not yet taken. Input beats are taken into a front
// stage and a two-entry queue while the back is busy or waiting in FIX.
// Configuration writes are taken every cycle and must be made while idle.
// ----------------------------------------------------------------------------
module torque_window_peak_to_drive import twpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] sample, [14:12] gear
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] drive
);

  cfg_t  cfg_q, cfg_d;
  logic  front_valid, fifo_full, fifo_empty, pop;
  item_t front_item, back_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE:     cfg_d.enable      = cfg_data_i[0];
        REG_WINDOW_LEN: cfg_d.window_len  = cfg_data_i[LEN_W-1:0];
        REG_OFFSET_MV:  cfg_d.offset_mv   = cfg_data_i[OFFS_W-1:0];
        REG_GEAR1_MAX:  cfg_d.gear_max[0] = cfg_data_i[TOP_W-1:0];
        REG_GEAR2_MAX:  cfg_d.gear_max[1] = cfg_data_i[TOP_W-1:0];
        REG_GEAR3_MAX:  cfg_d.gear_max[2] = cfg_data_i[TOP_W-1:0];
        REG_GEAR4_MAX:  cfg_d.gear_max[3] = cfg_data_i[TOP_W-1:0];
        REG_GEAR5_MAX:  cfg_d.gear_max[4] = cfg_data_i[TOP_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.window_len <= WIN_LEN_RESET;
      cfg_q.offset_mv  <= '0;
      cfg_q.gear_max   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  twpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid_o  (front_valid),
    .item_ready_i  (!fifo_full),
    .item_o        (front_item)
  );

  twpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_item_i (front_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_item_o  (back_item),
    .empty_o     (fifo_empty)
  );

  twpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (!fifo_empty),
    .item_i        (back_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== src/twpd_front.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive front
// Input stage: takes a beat, marks whether its sample is stored, hands it on.
// ----------------------------------------------------------------------------
module twpd_front import twpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [11:0] sample, [14:12] gear
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output item_t                item_o
);

  logic  hold_valid_q, hold_valid_d;
  item_t hold_q, hold_d;
  logic  take;

  assign s_axis_tready = !hold_valid_q || item_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    if (hold_valid_q && item_ready_i) begin
      hold_valid_d = 1'b0;
    end
    if (take) begin
      hold_valid_d  = 1'b1;
      hold_d.sample = s_axis_tdata[SAMPLE_W-1:0];
      hold_d.gear   = s_axis_tdata[SAMPLE_W+GEAR_W-1:SAMPLE_W];
      hold_d.store  = (s_axis_tdata[SAMPLE_W-1:0] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  assign item_valid_o = hold_valid_q;
  assign item_o       = hold_q;

endmodule

// ===== src/twpd_fifo.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module twpd_fifo import twpd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  empty_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNTF_W = $clog2(FIFO_DEPTH + 1);

  item_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNTF_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNTF_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNTF_W'(1);
      2'b01:   count_d = count_q - CNTF_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/twpd_back.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive back
// Window store, sequential peak scan, millivolt conversion and drive mapping.
// ----------------------------------------------------------------------------
module twpd_back import twpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] drive
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_SLOPE = 3'd4;
  localparam logic [2:0] S_RECIP = 3'd5;
  localparam logic [2:0] S_QUOT  = 3'd6;
  localparam logic [2:0] S_FIX   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] win_d [WINDOW_DEPTH];
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [GEAR_W-1:0]   gear_q, gear_d;
  logic [SAMPLE_W-1:0] best_q, best_d;
  logic [MVP_W-1:0]    mvp_q, mvp_d;
  logic                neg_q, neg_d;
  logic [MVC_W-1:0]    mvc_q, mvc_d;
  logic                sign_q, sign_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic [PROD_W-1:0]   recip_q, recip_d;
  logic [QUOT_W-1:0]   q0_q, q0_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  logic [DRIVE_W-1:0]  out_data_q, out_data_d;

  logic [IDX_W-1:0]          rd_idx;
  logic [SAMPLE_W-1:0]       mv;
  logic [SAMPLE_W:0]         diff;
  logic [2:0]                top_idx;
  logic [TOP_W-1:0]          top;
  logic                      gear_ok;
  logic signed [SLOPE_W-1:0] slope_s;
  logic [TOP_W-1:0]          slope_mag;
  logic [QUOT_W-1:0]         q0_w;
  logic [QUOT_W-1:0]         quot;
  logic signed [RES_W-1:0]   res;
  logic [DRIVE_W-1:0]        drive;

  assign rd_idx  = IDX_W'(WINDOW_DEPTH - 1) - cnt_q[IDX_W-1:0];
  assign mv      = SAMPLE_W'(mvp_q >> ADC_SHIFT);
  assign diff    = {1'b0, mv} - {1'b0, cfg_i.offset_mv};
  assign gear_ok = (gear_q != '0) && (32'(gear_q) <= GEAR_COUNT);
  assign top_idx = gear_q - 3'd1;
  assign top     = gear_ok ? cfg_i.gear_max[top_idx] : '0;
  assign slope_s = $signed({2'b00, top}) - $signed(SLOPE_W'(OUT_MIN));
  assign slope_mag = slope_s[SLOPE_W-1] ? TOP_W'(-slope_s) : TOP_W'(slope_s);
  assign q0_w    = QUOT_W'(recip_q >> RECIP_SHIFT);
  assign quot    = q0_q + QUOT_W'(rem_q >= REM_W'(MAP_SPAN));
  assign res     = sign_q ? ($signed(RES_W'(OUT_MIN)) - $signed(RES_W'(quot)))
                          : ($signed(RES_W'(OUT_MIN)) + $signed(RES_W'(quot)));

  always_comb begin
    if (res[RES_W-1]) begin
      drive = '0;
    end else if (res > $signed(RES_W'(DRIVE_MAX))) begin
      drive = DRIVE_W'(DRIVE_MAX);
    end else begin
      drive = res[DRIVE_W-1:0];
    end
    if (!cfg_i.enable || neg_q || !gear_ok) begin
      drive = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    gear_d      = gear_q;
    best_d      = best_q;
    mvp_d       = mvp_q;
    neg_d       = neg_q;
    mvc_d       = mvc_q;
    sign_d      = sign_q;
    mag_d       = mag_q;
    recip_d     = recip_q;
    q0_d        = q0_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          gear_d = item_i.gear;
          best_d = '0;
          cnt_d  = '0;
          if (32'(cfg_i.window_len) > WINDOW_DEPTH) begin
            n_d = CNT_W'(WINDOW_DEPTH);
          end else begin
            n_d = CNT_W'(cfg_i.window_len);
          end
          if (item_i.store) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            win_d[WINDOW_DEPTH-1] = item_i.sample;
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == n_q) begin
          state_d = S_MUL;
        end else begin
          if (win_q[rd_idx] > best_q) begin
            best_d = win_q[rd_idx];
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_MUL: begin
        mvp_d   = MVP_W'(best_q) * MVP_W'(MV_SPAN);
        state_d = S_SUB;
      end
      S_SUB: begin
        neg_d = diff[SAMPLE_W];
        if (diff[SAMPLE_W-1:0] > SAMPLE_W'(MV_CLAMP)) begin
          mvc_d = MVC_W'(MV_CLAMP);
        end else begin
          mvc_d = MVC_W'(diff[SAMPLE_W-1:0]);
        end
        state_d = S_SLOPE;
      end
      S_SLOPE: begin
        sign_d  = slope_s[SLOPE_W-1];
        mag_d   = MAG_W'(mvc_q) * MAG_W'(slope_mag);
        state_d = S_RECIP;
      end
      S_RECIP: begin
        recip_d = PROD_W'(mag_q) * PROD_W'(RECIP);
        state_d = S_QUOT;
      end
      S_QUOT: begin
        q0_d    = q0_w;
        rem_d   = REM_W'(mag_q) - REM_W'(32'(q0_w) * MAP_SPAN);
        state_d = S_FIX;
      end
      S_FIX: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = drive;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    gear_q     <= gear_d;
    best_q     <= best_d;
    mvp_q      <= mvp_d;
    neg_q      <= neg_d;
    mvc_q      <= mvc_d;
    sign_q     <= sign_d;
    mag_q      <= mag_d;
    recip_q    <= recip_d;
    q0_q       <= q0_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_data_q);

endmodule

// ===== src/twpd_checker.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive checker
// Port-level checks on pending results, in-flight bound and output holding.
// ----------------------------------------------------------------------------
`include "torque_window_peak_to_drive_assert.svh"

module twpd_checker import twpd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int MAX_INFLIGHT = FIFO_DEPTH + 3;
  localparam int PEND_W = $clog2(MAX_INFLIGHT + 2);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic              in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    case ({in_beat, out_beat})
      2'b10:   pend_d = pend_q + PEND_W'(1);
      2'b01:   pend_d = pend_q - PEND_W'(1);
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `TWPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled drive beat changed")
  `TWPD_ASSERT_SAME(a_no_orphan, m_axis_tvalid, pend_q != '0, "drive beat without a pending input")
  `TWPD_ASSERT_SAME(a_bound, 1'b1, pend_q <= PEND_W'(MAX_INFLIGHT), "too many items in flight")
  `TWPD_ASSERT_SAME(a_full_stall, pend_q == PEND_W'(MAX_INFLIGHT) && !out_beat, !s_axis_tready, "input taken while full")

endmodule

bind torque_window_peak_to_drive twpd_checker u_checker (.*);

// ===== dv/tb_torque_window_peak_to_drive.sv =====
// ----------------------------------------------------------------------------
// Torque window peak to drive testbench
// Drives sample and gear beats into the block under random idling and
// back-pressure, keeps its own copy of the sample window and the register
// settings, and checks every drive beat against the predicted value in order.
// Register settings change between phases, only once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_torque_window_peak_to_drive;
  import twpd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [11:0] sample, [14:12] gear
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] drive

  logic [SAMPLE_W-1:0] win_hist [WINDOW_DEPTH];
  logic                cfg_enable;
  logic [LEN_W-1:0]    cfg_win_len;
  logic [OFFS_W-1:0]   cfg_offset;
  logic [TOP_W-1:0]    cfg_gear_top [GEAR_COUNT];

  logic [DRIVE_W-1:0] drive_expected [$];
  int                 errors;
  int                 stall_cycles;
  bit                 tx_steady;
  bit                 rx_steady;
  int                 rx_hold;

  torque_window_peak_to_drive uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [DRIVE_W-1:0] predict_drive(logic [GEAR_W-1:0] gear);
    int unsigned n;
    logic [SAMPLE_W-1:0] peak;
    int mv;
    int r;
    n = (cfg_win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : cfg_win_len;
    peak = '0;
    for (int i = WINDOW_DEPTH - n; i < WINDOW_DEPTH; i++) begin
      if (win_hist[i] > peak) peak = win_hist[i];
    end
    mv = int'(peak) * MV_SPAN / ADC_SPAN - int'(cfg_offset);
    if (!cfg_enable || mv < 0 || gear == 0 || gear > GEAR_COUNT) return '0;
    if (mv > MV_CLAMP) mv = MV_CLAMP;
    r = mv * (int'(cfg_gear_top[gear - 1]) - OUT_MIN) / MAP_SPAN + OUT_MIN;
    if (r < 0) r = 0;
    if (r > DRIVE_MAX) r = DRIVE_MAX;
    return DRIVE_W'(r);
  endfunction

  task automatic flag_error(input string what, input logic [DRIVE_W-1:0] want,
                            input logic [DRIVE_W-1:0] got);
    errors++;
    if (errors <= 10) $display("%0t: %s: expected drive %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic [GEAR_W-1:0] gear);
    if (!tx_steady) begin
      while ($urandom_range(99) < 29) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, gear, sample};
    do @(posedge clk_i); while (!s_axis_tready);
    if (sample != 0) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_hist[i] = win_hist[i + 1];
      win_hist[WINDOW_DEPTH - 1] = sample;
    end
    drive_expected.push_back(predict_drive(gear));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ENABLE:     cfg_enable = data[0];
      REG_WINDOW_LEN: cfg_win_len = data[LEN_W-1:0];
      REG_OFFSET_MV:  cfg_offset = data[OFFS_W-1:0];
      REG_GEAR1_MAX:  cfg_gear_top[0] = data[TOP_W-1:0];
      REG_GEAR2_MAX:  cfg_gear_top[1] = data[TOP_W-1:0];
      REG_GEAR3_MAX:  cfg_gear_top[2] = data[TOP_W-1:0];
      REG_GEAR4_MAX:  cfg_gear_top[3] = data[TOP_W-1:0];
      REG_GEAR5_MAX:  cfg_gear_top[4] = data[TOP_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // keep the unused upper data bits random so every bus bit toggles
  function automatic logic [CFG_DATA_W-1:0] pad_data(input int unsigned value, input int width);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    return (noise & ~((CFG_DATA_W'(1) << width) - 1)) | CFG_DATA_W'(value);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 15) return SAMPLE_W'(4095);
    if (r < 40) return SAMPLE_W'($urandom_range(200, 1));
    return SAMPLE_W'($urandom_range(4095, 1));
  endfunction

  function automatic logic [GEAR_W-1:0] pick_gear();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 16) return GEAR_W'($urandom_range(7, 6));
    return GEAR_W'($urandom_range(GEAR_COUNT, 1));
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample(), pick_gear());
  endtask

  task automatic test_reset_state();
    send_sample(12'd4095, 3'd1);
    send_sample(12'd0, 3'd2);
    send_sample(12'd2000, 3'd5);
    wait_drained();
    // reset window length stays in force: enable without writing it
    write_reg(REG_ENABLE, pad_data(1, 1));
    write_reg(REG_GEAR1_MAX, pad_data(255, TOP_W));
    send_sample(12'd1, 3'd1);
    wait_drained();
  endtask

  task automatic test_directed();
    write_reg(REG_GEAR2_MAX, pad_data(100, TOP_W));
    write_reg(REG_GEAR3_MAX, pad_data(1, TOP_W));
    write_reg(REG_GEAR4_MAX, pad_data(0, TOP_W));
    write_reg(REG_GEAR5_MAX, pad_data(254, TOP_W));
    write_reg(REG_OFFSET_MV, pad_data(0, OFFS_W));
    write_reg(REG_WINDOW_LEN, pad_data(16, LEN_W));
    for (int g = 0; g < 8; g++) send_sample(12'd4095, GEAR_W'(g));
    send_sample(12'd0, 3'd1);
    send_sample(12'd1862, 3'd2);
    wait_drained();
    write_reg(REG_WINDOW_LEN, pad_data(1, LEN_W));
    send_sample(12'd0, 3'd1);
    send_sample(12'd1, 3'd5);
    send_sample(12'd2048, 3'd5);
    send_sample(12'd1861, 3'd1);
    wait_drained();
    write_reg(REG_WINDOW_LEN, pad_data(0, LEN_W));
    send_sample(12'd4095, 3'd1);
    wait_drained();
    write_reg(REG_WINDOW_LEN, pad_data(31, LEN_W));
    send_sample(12'd1, 3'd1);
    wait_drained();
    write_reg(REG_OFFSET_MV, pad_data(3301, OFFS_W));
    send_sample(12'd4095, 3'd1);
    wait_drained();
    write_reg(REG_OFFSET_MV, pad_data(4095, OFFS_W));
    write_reg(REG_WINDOW_LEN, pad_data(2, LEN_W));
    send_sample(12'd4095, 3'd5);
    wait_drained();
    write_reg(REG_OFFSET_MV, pad_data(1000, OFFS_W));
    send_sample(12'd2000, 3'd1);
    send_sample(12'd1000, 3'd1);
    send_sample(12'd3000, 3'd3);
    wait_drained();
  endtask

  task automatic test_unknown_index();
    for (int idx = REG_GEAR5_MAX + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    end
    send_random(5);
    wait_drained();
  endtask

  task automatic apply_random_settings(input int phase);
    int unsigned len;
    int unsigned offs;
    int unsigned r;
    r = $urandom_range(99);
    len = (r < 10) ? 0 : (r < 25) ? $urandom_range(31, 17) : $urandom_range(16, 1);
    r = $urandom_range(99);
    offs = (r < 50) ? $urandom_range(800) : $urandom_range(4095);
    if (phase == 1) begin
      len = 31;
      offs = 0;
    end else if (phase == 2) begin
      len = 0;
      offs = 4095;
    end
    write_reg(REG_ENABLE, pad_data(($urandom_range(99) < 85) ? 1 : 0, 1));
    write_reg(REG_WINDOW_LEN, pad_data(len, LEN_W));
    write_reg(REG_OFFSET_MV, pad_data(offs, OFFS_W));
    for (int g = 0; g < GEAR_COUNT; g++) begin
      r = $urandom_range(99);
      write_reg(REG_GEAR1_MAX + CFG_IDX_W'(g),
                pad_data((r < 15) ? 0 : (r < 30) ? 255 : $urandom_range(255), TOP_W));
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      apply_random_settings(phase);
      tx_steady = (phase == 0);
      rx_steady = (phase == 0);
      send_random(150);
      wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_back_pressure();
    apply_random_settings(3);
    rx_hold = HOLD_CYCLES;
    send_random(40);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    apply_random_settings(4);
    send_random(30);
    wait_drained();
    send_random(30);
    wait_drained();
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expected.size() == 0) begin
        flag_error("unexpected drive beat", '0, m_axis_tdata);
      end else if (m_axis_tdata !== drive_expected[0]) begin
        flag_error("drive mismatch", drive_expected.pop_front(), m_axis_tdata);
      end else begin
        void'(drive_expected.pop_front());
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("torque_window_peak_to_drive test failed");
    $finish;
  end

  initial begin
    errors        = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_hold       = 0;
    cfg_enable    = 1'b0;
    cfg_win_len   = WIN_LEN_RESET;
    cfg_offset    = '0;
    for (int g = 0; g < GEAR_COUNT; g++) cfg_gear_top[g] = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) win_hist[i] = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed();
    test_unknown_index();
    test_random_settings();
    test_back_pressure();
    test_sender_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (drive_expected.size() != 0) flag_error("drive beat missing", drive_expected[0], '0);
    if (errors == 0) begin
      $display("torque_window_peak_to_drive test passed");
    end else begin
      $display("torque_window_peak_to_drive test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/twpd_pkg.sv
src/twpd_front.sv
src/twpd_fifo.sv
src/twpd_back.sv
src/torque_window_peak_to_drive.sv
src/twpd_checker.sv
dv/tb_torque_window_peak_to_drive.sv
